[src/json_bracket_matcher_unit_macros.svh]
// ----------------------------------------------------------------------------
// json_bracket_matcher_unit_macros.svh
// Assertion shorthands used by the bracket matcher checker.
// ----------------------------------------------------------------------------
`ifndef JSON_BRACKET_MATCHER_UNIT_MACROS_SVH
`define JSON_BRACKET_MATCHER_UNIT_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define JBM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that an expression never holds
`define JBM_ASSERT_NEVER(label, expr, msg) \
	`JBM_ASSERT(label, !(expr), msg)

`endif

[src/jbm_pkg.sv]
// ----------------------------------------------------------------------------
// jbm_pkg
// Types and constants of the string-aware bracket matcher.
// ----------------------------------------------------------------------------
package jbm_pkg;

	// Stream field widths
	localparam int TEXT_W     = 8;
	localparam int IDX_W      = 16;
	localparam int IN_DATA_W  = TEXT_W + IDX_W;
	localparam int OUT_DATA_W = IDX_W;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OPEN_TOKEN  = 1'b0,
		REG_CLOSE_TOKEN = 1'b1
	} cfg_reg_t;

	localparam logic [TEXT_W-1:0] OPEN_RESET  = 8'h7B;
	localparam logic [TEXT_W-1:0] CLOSE_RESET = 8'h7D;

	// Bytes with fixed meaning inside the text
	localparam logic [TEXT_W-1:0] CH_BACKSLASH = 8'h5C;
	localparam logic [TEXT_W-1:0] CH_QUOTE     = 8'h22;

	// Match status codes
	localparam logic STATUS_FOUND     = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	// Scan flags kept across bytes
	typedef struct packed {
		logic inside_string;
		logic escape_pending;
		logic scan_done;
	} scan_state_t;

	// Outcome of one byte
	typedef struct packed {
		logic valid;
		logic status;
	} scan_result_t;

endpackage

[src/jbm_scan.sv]
// ----------------------------------------------------------------------------
// jbm_scan
// Next-state logic of the bracket scan for one text byte.
// ----------------------------------------------------------------------------
module jbm_scan #(
	parameter int DEPTH_BITS = 16
) (
	input  jbm_pkg::scan_state_t          state,
	input  logic signed [DEPTH_BITS-1:0]  depth,
	input  logic [jbm_pkg::TEXT_W-1:0]    text_byte,
	input  logic                          scan_start,
	input  logic                          text_end,
	input  logic [jbm_pkg::TEXT_W-1:0]    open_token,
	input  logic [jbm_pkg::TEXT_W-1:0]    close_token,
	output jbm_pkg::scan_state_t          state_next,
	output logic signed [DEPTH_BITS-1:0]  depth_next,
	output jbm_pkg::scan_result_t         result
);
	import jbm_pkg::*;

	localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

	scan_state_t                  cur;
	logic signed [DEPTH_BITS-1:0] cur_depth;
	logic signed [DEPTH_BITS-1:0] dec_depth;

	// Clear the scan on a start byte before it is processed
	always_comb begin
		if (scan_start) begin
			cur       = '0;
			cur_depth = '0;
		end else begin
			cur       = state;
			cur_depth = depth;
		end
	end

	// Saturating decrement
	assign dec_depth = (cur_depth != DEPTH_MIN) ? cur_depth - DEPTH_BITS'(1) : cur_depth;

	// Step the flags and depth; report a match or the end of text
	always_comb begin
		state_next = cur;
		depth_next = cur_depth;
		result     = '0;
		if (!cur.scan_done) begin
			priority if (cur.inside_string) begin
				priority if (cur.escape_pending) begin
					state_next.escape_pending = 1'b0;
				end else if (text_byte == CH_BACKSLASH) begin
					state_next.escape_pending = 1'b1;
				end else if (text_byte == CH_QUOTE) begin
					state_next.inside_string = 1'b0;
				end else begin
					// Any other byte inside a string changes nothing
				end
			end else if (text_byte == CH_QUOTE) begin
				state_next.inside_string = 1'b1;
			end else if (text_byte == open_token) begin
				if (cur_depth != DEPTH_MAX) begin
					depth_next = cur_depth + DEPTH_BITS'(1);
				end
			end else if (text_byte == close_token) begin
				depth_next = dec_depth;
				if (dec_depth == '0) begin
					state_next.scan_done = 1'b1;
					result.valid         = 1'b1;
					result.status        = STATUS_FOUND;
				end
			end else begin
				// Ordinary byte: hold flags and depth
			end
			// End of text without a match
			if (text_end && !result.valid) begin
				state_next.scan_done = 1'b1;
				result.valid         = 1'b1;
				result.status        = STATUS_NOT_FOUND;
			end
		end
	end

endmodule

[src/json_bracket_matcher_unit.sv]
// ----------------------------------------------------------------------------
// json_bracket_matcher_unit
// Finds the close token that balances the first open token of a scan,
// skipping quoted strings with backslash escapes.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_*      in   tdata = text_byte, byte_index; tuser = scan_start; tlast = text_end
// m_*      out  tdata = match_index; tuser = match_status
// cfg_*    in   write of open_token (index 0) or close_token (index 1)
//
// One byte per cycle when not stalled; the result shows on m_* in the cycle
// after the byte that causes it. A single pass of flag and depth logic sits
// between the scan state and the output register. s_tready drops only while
// the output register holds a result that m_tready does not take. Reset clears
// the scan to idle (waiting for a start byte) and loads brace tokens.
// ----------------------------------------------------------------------------
module json_bracket_matcher_unit #(
	parameter int INDEX_BITS = 16,
	parameter int DEPTH_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [jbm_pkg::IN_DATA_W-1:0]     s_tdata,   // text_byte, byte_index
	input  logic                              s_tuser,   // scan_start
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [jbm_pkg::OUT_DATA_W-1:0]    m_tdata,   // match_index
	output logic                              m_tuser,   // match_status
	input  logic                              cfg_we,
	input  logic [jbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jbm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import jbm_pkg::*;

	localparam int IDX_KEEP = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;

	logic [TEXT_W-1:0]            open_token_q;
	logic [TEXT_W-1:0]            close_token_q;
	scan_state_t                  state_q;
	logic signed [DEPTH_BITS-1:0] depth_q;
	scan_state_t                  state_next;
	logic signed [DEPTH_BITS-1:0] depth_next;
	scan_result_t                 result;
	logic                         out_valid_q;
	logic                         status_q;
	logic [IDX_KEEP-1:0]          match_index_q;
	logic                         in_xfer;
	logic [TEXT_W-1:0]            text_byte;
	logic [IDX_W-1:0]             byte_index;

	assign text_byte  = s_tdata[TEXT_W-1:0];
	assign byte_index = s_tdata[IN_DATA_W-1:TEXT_W];

	// Accept while the output register is free or being drained
	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	// Token registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_token_q  <= OPEN_RESET;
			close_token_q <= CLOSE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OPEN_TOKEN:  open_token_q  <= cfg_data;
				REG_CLOSE_TOKEN: close_token_q <= cfg_data;
			endcase
		end
	end

	jbm_scan #(
		.DEPTH_BITS (DEPTH_BITS)
	) u_scan (
		.state       (state_q),
		.depth       (depth_q),
		.text_byte   (text_byte),
		.scan_start  (s_tuser),
		.text_end    (s_tlast),
		.open_token  (open_token_q),
		.close_token (close_token_q),
		.state_next  (state_next),
		.depth_next  (depth_next),
		.result      (result)
	);

	// Advance the scan state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{inside_string: 1'b0, escape_pending: 1'b0, scan_done: 1'b1};
			depth_q <= '0;
		end else if (in_xfer) begin
			state_q <= state_next;
			depth_q <= depth_next;
		end
	end

	// Output valid: load on a result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= result.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; index is zero when nothing was found
	always_ff @(posedge clk) begin
		if (in_xfer && result.valid) begin
			status_q <= result.status;
			if (result.status == STATUS_FOUND) begin
				match_index_q <= byte_index[IDX_KEEP-1:0];
			end else begin
				match_index_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = OUT_DATA_W'(match_index_q);

endmodule

[src/jbm_checker.sv]
// ----------------------------------------------------------------------------
// jbm_checker
// Port-level checks of the bracket matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_bracket_matcher_unit_macros.svh"

module jbm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tlast,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [jbm_pkg::OUT_DATA_W-1:0]    m_tdata,
	input logic                              m_tuser
);
	import jbm_pkg::*;

	// Hold a result until it is taken
	`JBM_ASSERT(a_hold_valid, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")

	// A not-found report carries a zero index
	`JBM_ASSERT(a_notfound_zero, (m_tvalid && m_tuser == STATUS_NOT_FOUND) |-> (m_tdata == '0), "nonzero index on not-found")

	// A result appears only after an input transfer
	`JBM_ASSERT(a_no_spurious, !(s_tvalid && s_tready) |=> !$rose(m_tvalid), "result without input")

	// Only the last byte of a text can report not-found
	`JBM_ASSERT_NEVER(a_notfound_last, $past(s_tvalid && s_tready && !s_tlast) && m_tvalid && m_tuser == STATUS_NOT_FOUND, "not-found before end of text")

endmodule

bind json_bracket_matcher_unit jbm_checker u_jbm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
